// ===== src/look_at_view_matrix_macros.svh =====
// assertion macros for the look-at view matrix block
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH

// same-cycle implication
`define LAVM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LAVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lavm_pkg.sv =====
// types and constants shared by the look-at view matrix block
package lavm_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int UNIT_W      = 18;
  localparam int UP_W        = 19;
  localparam int VEC_W       = 49;
  localparam int MAG_W       = 48;
  localparam int NORM_BITS   = 30;
  localparam int SQ_W        = 63;
  localparam int ROOT_W      = 31;
  localparam int QUO_W       = 18;
  localparam int ACC_W       = 64;
  localparam int SQRT_STEPS  = 32;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] upvec_x;
    logic signed [31:0] upvec_y;
    logic signed [31:0] upvec_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] row0_x;
    logic signed [31:0] row0_y;
    logic signed [31:0] row0_z;
    logic signed [31:0] row0_shift;
    logic signed [31:0] row1_x;
    logic signed [31:0] row1_y;
    logic signed [31:0] row1_z;
    logic signed [31:0] row1_shift;
    logic signed [31:0] row2_x;
    logic signed [31:0] row2_y;
    logic signed [31:0] row2_z;
    logic signed [31:0] row2_shift;
  } out_item_t;

  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] upv;
    logic [2:0][32:0] diff;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_req_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABS,
    ST_NORM,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_CROSS,
    ST_UP,
    ST_SHIFT,
    ST_OUT
  } state_t;

  typedef enum logic {
    PH_FWD,
    PH_SIDE
  } phase_t;

endpackage

// ===== src/lavm_front.sv =====
// front end: item intake and forward difference
module lavm_front import lavm_pkg::*; (
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  input  q_status_t q_status,
  output job_req_t  push
);

  assign in_stall   = q_status.full;
  assign push.valid = in_valid && !q_status.full;

  assign push.job.eye[0] = in_item.eye_x;
  assign push.job.eye[1] = in_item.eye_y;
  assign push.job.eye[2] = in_item.eye_z;
  assign push.job.upv[0] = in_item.upvec_x;
  assign push.job.upv[1] = in_item.upvec_y;
  assign push.job.upv[2] = in_item.upvec_z;
  assign push.job.diff[0] = 33'(in_item.target_x) - 33'(in_item.eye_x);
  assign push.job.diff[1] = 33'(in_item.target_y) - 33'(in_item.eye_y);
  assign push.job.diff[2] = 33'(in_item.target_z) - 33'(in_item.eye_z);

endmodule

// ===== src/lavm_queue.sv =====
// short queue between front and back end
`include "look_at_view_matrix_macros.svh"
module lavm_queue import lavm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  job_req_t  push,
  input  logic      pop,
  output q_status_t q_status,
  output job_t      rd_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign q_status.valid = (cnt_r != '0);
  assign q_status.full  = (cnt_r == CW'(DEPTH));
  assign rd_job         = mem[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.valid && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push.valid && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr_r] <= push.job;
    end
  end

  `LAVM_ASSERT_NOW(a_no_push_full, push.valid, !q_status.full, "push into full queue")
  `LAVM_ASSERT_NOW(a_no_pop_empty, pop, q_status.valid, "pop from empty queue")
  `LAVM_ASSERT_NEXT(a_cnt_up, push.valid && !pop, cnt_r == $past(cnt_r) + 1'b1,
                    "queue count did not rise on push")

endmodule

// ===== src/lavm_back.sv =====
// back end: normalisation, cross products, translation and result register
`include "look_at_view_matrix_macros.svh"
module lavm_back import lavm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_status_t q_status,
  input  job_t      q_job,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  state_t state_r, state_nxt;
  phase_t phase_r;
  logic [1:0] comp_r, idx_r;
  logic [4:0] cnt_r;

  logic signed [31:0]       eye_r  [3];
  logic signed [31:0]       upv_r  [3];
  logic signed [VEC_W-1:0]  vec_r  [3];
  logic [MAG_W-1:0]         mag_r  [3];
  logic                     neg_r  [3];
  logic signed [UNIT_W-1:0] fwd_r  [3];
  logic signed [UNIT_W-1:0] side_r [3];
  logic signed [UP_W-1:0]   up_r   [3];
  logic signed [31:0]       shift_r[3];

  logic [SQ_W-1:0]   rn_r, rr_r;
  logic [ROOT_W-1:0] len_r;
  logic [31:0]       rem_r;
  logic [QUO_W-1:0]  nlo_r, quo_r;

  logic signed [ACC_W-1:0] acc_r, prod_r, prod_nxt, mac_sum;
  logic                    psub_r;

  logic signed [31:0] mac_a, mac_b;
  logic               mac_sub;
  logic [1:0]         mac_last;
  logic               load_out, out_free, out_valid_r;
  out_item_t          out_item_r;

  logic [1:0] c1, c2, tsel;
  logic       any_big, mac_done, comp_done, div_done;

  logic [SQ_W-1:0]  sq_bit, sq_try, rr_nxt;
  logic             sq_ge;
  logic [MAG_W-1:0] dnum;
  logic [32:0]      rem2, dvs;
  logic             dge;
  logic [QUO_W-1:0] qfin;
  logic signed [UNIT_W-1:0] unit_val;

  function automatic logic [1:0] nxt3(input logic [1:0] c);
    logic [1:0] r;
    case (c)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [47:0] rnd16(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + 64'sd32768;
    return t[63:16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh7FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -48'sh80000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign c1   = nxt3(comp_r);
  assign c2   = nxt3(c1);
  assign tsel = (idx_r == 2'd3) ? 2'd0 : idx_r;

  assign any_big = (mag_r[0][MAG_W-1:NORM_BITS] != '0) || (mag_r[1][MAG_W-1:NORM_BITS] != '0)
                || (mag_r[2][MAG_W-1:NORM_BITS] != '0);

  assign prod_nxt  = mac_a * mac_b;
  assign mac_sum   = acc_r + (psub_r ? -prod_r : prod_r);
  assign mac_done  = (idx_r == mac_last);
  assign comp_done = (comp_r == 2'd2);
  assign div_done  = (cnt_r == 5'd18);
  assign out_free  = !out_valid_r || !out_stall;

  // square root, two bits a step
  assign sq_bit = SQ_W'(1) << (6'd62 - {cnt_r, 1'b0});
  assign sq_try = rr_r + sq_bit;
  assign sq_ge  = (rn_r >= sq_try);
  assign rr_nxt = sq_ge ? ((rr_r >> 1) + sq_bit) : (rr_r >> 1);

  // rounded quotient, one bit a step
  assign dnum     = {1'b0, mag_r[comp_r][NORM_BITS-1:0], 17'd0} + MAG_W'(len_r);
  assign rem2     = {rem_r, nlo_r[QUO_W-1]};
  assign dvs      = {1'b0, len_r, 1'b0};
  assign dge      = (rem2 >= dvs);
  assign qfin     = {quo_r[QUO_W-2:0], dge};
  assign unit_val = (len_r == '0) ? '0
                  : (neg_r[comp_r] ? -$signed(qfin) : $signed(qfin));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (q_status.valid) state_nxt = ST_ABS;
      ST_ABS:   state_nxt = ST_NORM;
      ST_NORM:  if (!any_big) state_nxt = ST_SQ;
      ST_SQ:    if (mac_done) state_nxt = ST_SQRT;
      ST_SQRT:  if (cnt_r == 5'(SQRT_STEPS - 1)) state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done && comp_done) begin
          state_nxt = (phase_r == PH_FWD) ? ST_CROSS : ST_UP;
        end
      end
      ST_CROSS: if (mac_done && comp_done) state_nxt = ST_ABS;
      ST_UP:    if (mac_done && comp_done) state_nxt = ST_SHIFT;
      ST_SHIFT: if (mac_done && comp_done) state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    mac_a    = '0;
    mac_b    = '0;
    mac_sub  = 1'b0;
    mac_last = 2'd0;
    unique case (state_r)
      ST_IDLE: q_pop = q_status.valid;
      ST_SQ: begin
        mac_a    = {2'b00, mag_r[tsel][NORM_BITS-1:0]};
        mac_b    = {2'b00, mag_r[tsel][NORM_BITS-1:0]};
        mac_last = 2'd3;
      end
      ST_CROSS: begin
        mac_last = 2'd2;
        if (idx_r[0] == 1'b0) begin
          mac_a = upv_r[c2];
          mac_b = 32'(fwd_r[c1]);
        end else begin
          mac_a   = upv_r[c1];
          mac_b   = 32'(fwd_r[c2]);
          mac_sub = 1'b1;
        end
      end
      ST_UP: begin
        mac_last = 2'd2;
        if (idx_r[0] == 1'b0) begin
          mac_a = 32'(side_r[c1]);
          mac_b = 32'(fwd_r[c2]);
        end else begin
          mac_a   = 32'(side_r[c2]);
          mac_b   = 32'(fwd_r[c1]);
          mac_sub = 1'b1;
        end
      end
      ST_SHIFT: begin
        mac_last = 2'd3;
        mac_a    = eye_r[tsel];
        mac_sub  = (comp_r != 2'd2);
        case (comp_r)
          2'd0:    mac_b = 32'(side_r[tsel]);
          2'd1:    mac_b = 32'(up_r[tsel]);
          default: mac_b = 32'(fwd_r[tsel]);
        endcase
      end
      ST_OUT: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_FWD;
      comp_r      <= 2'd0;
      idx_r       <= 2'd0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        phase_r <= PH_FWD;
      end else if (state_r == ST_CROSS && mac_done && comp_done) begin
        phase_r <= PH_SIDE;
      end
      case (state_r)
        ST_SQ, ST_CROSS, ST_UP, ST_SHIFT: idx_r <= mac_done ? 2'd0 : idx_r + 1'b1;
        default: idx_r <= 2'd0;
      endcase
      case (state_r)
        ST_SQRT: cnt_r <= (cnt_r == 5'(SQRT_STEPS - 1)) ? '0 : cnt_r + 1'b1;
        ST_DIV:  cnt_r <= div_done ? '0 : cnt_r + 1'b1;
        default: cnt_r <= '0;
      endcase
      case (state_r)
        ST_IDLE: comp_r <= 2'd0;
        ST_DIV:  if (div_done) comp_r <= comp_done ? 2'd0 : comp_r + 1'b1;
        ST_CROSS, ST_UP, ST_SHIFT: begin
          if (mac_done) comp_r <= comp_done ? 2'd0 : comp_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    psub_r <= mac_sub;
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          for (int i = 0; i < 3; i++) begin
            eye_r[i] <= q_job.eye[i];
            upv_r[i] <= q_job.upv[i];
            vec_r[i] <= VEC_W'($signed(q_job.diff[i]));
          end
        end
      end
      ST_ABS: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= vec_r[i][VEC_W-1];
          mag_r[i] <= vec_r[i][VEC_W-1] ? MAG_W'(-vec_r[i]) : MAG_W'(vec_r[i]);
        end
      end
      ST_NORM: begin
        if (any_big) begin
          for (int i = 0; i < 3; i++) begin
            mag_r[i] <= mag_r[i] >> 1;
          end
        end
      end
      ST_SQ: begin
        acc_r <= (idx_r == 2'd0) ? '0 : mac_sum;
        if (mac_done) begin
          rn_r <= mac_sum[SQ_W-1:0];
          rr_r <= '0;
        end
      end
      ST_SQRT: begin
        if (sq_ge) begin
          rn_r <= rn_r - sq_try;
        end
        rr_r  <= rr_nxt;
        len_r <= rr_nxt[ROOT_W-1:0];
      end
      ST_DIV: begin
        if (cnt_r == '0) begin
          rem_r <= 32'(dnum[MAG_W-1:QUO_W]);
          nlo_r <= dnum[QUO_W-1:0];
          quo_r <= '0;
        end else begin
          rem_r <= dge ? 32'(rem2 - dvs) : rem2[31:0];
          nlo_r <= nlo_r << 1;
          quo_r <= qfin;
          if (div_done) begin
            if (phase_r == PH_FWD) begin
              fwd_r[comp_r] <= unit_val;
            end else begin
              side_r[comp_r] <= unit_val;
            end
          end
        end
      end
      ST_CROSS: begin
        acc_r <= (idx_r == 2'd0) ? '0 : mac_sum;
        if (mac_done) vec_r[comp_r] <= VEC_W'(mac_sum);
      end
      ST_UP: begin
        acc_r <= (idx_r == 2'd0) ? '0 : mac_sum;
        if (mac_done) up_r[comp_r] <= UP_W'(rnd16(mac_sum));
      end
      ST_SHIFT: begin
        acc_r <= (idx_r == 2'd0) ? '0 : mac_sum;
        if (mac_done) shift_r[comp_r] <= sat32(rnd16(mac_sum));
      end
      default: ;
    endcase
    if (load_out) begin
      out_item_r.row0_x     <= 32'(side_r[0]);
      out_item_r.row0_y     <= 32'(side_r[1]);
      out_item_r.row0_z     <= 32'(side_r[2]);
      out_item_r.row0_shift <= shift_r[0];
      out_item_r.row1_x     <= 32'(up_r[0]);
      out_item_r.row1_y     <= 32'(up_r[1]);
      out_item_r.row1_z     <= 32'(up_r[2]);
      out_item_r.row1_shift <= shift_r[1];
      out_item_r.row2_x     <= -(32'(fwd_r[0]));
      out_item_r.row2_y     <= -(32'(fwd_r[1]));
      out_item_r.row2_z     <= -(32'(fwd_r[2]));
      out_item_r.row2_shift <= shift_r[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `LAVM_ASSERT_NOW(a_norm_range, state_r == ST_DIV,
                   mag_r[comp_r][MAG_W-1:NORM_BITS] == '0, "magnitude not normalised")
  `LAVM_ASSERT_NOW(a_mag_le_len, state_r == ST_DIV && len_r != '0,
                   mag_r[comp_r] <= MAG_W'(len_r), "component exceeds vector length")
  `LAVM_ASSERT_NEXT(a_out_load, state_r == ST_OUT && out_free, out_valid_r,
                    "finished item not presented")

endmodule

// ===== src/look_at_view_matrix.sv =====
// Look-at view matrix, signed Q16.16, top level.
// in channel: in_valid / in_stall / in_item carries eye, target and up vector.
// out channel: out_valid / out_stall / out_item carries three matrix rows,
// each with its translation term; every item gives exactly one result.
// The front end forms target minus eye and writes the item into a short queue;
// items are taken while the back end is busy until the queue fills.
// The back end handles one item at a time with one shared 32x32 multiplier,
// a two-bits-a-step square root and a one-bit-a-step divider; the time per item is
// set by two square roots and six quotients, varying with the normalising shift loop.
// The result sits in an output register; while out_stall is high it holds,
// and the back end goes on to the next item once the result is loaded into it.
// Synchronous active-low reset empties the queue and drops any result.
module look_at_view_matrix import lavm_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  job_req_t  push;
  q_status_t q_status;
  job_t      q_job;
  logic      q_pop;

  lavm_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_status (q_status),
    .push     (push)
  );

  lavm_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (q_pop),
    .q_status (q_status),
    .rd_job   (q_job)
  );

  lavm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== bench/tb_look_at_view_matrix.sv =====
// testbench for the look-at view matrix block: directed table, then random items
`timescale 1ns / 100ps

module tb_look_at_view_matrix;
  import lavm_pkg::*;

  typedef longint vec3_t [3];

  typedef struct {
    in_item_t  stim;
    bit        known;
    out_item_t want;
  } view_row_t;

  localparam int N_RANDOM   = 1130;
  localparam int CYCLE_CAP  = 3000000;
  localparam int HOLD_LEN   = 2000;
  localparam int HOLD_AT    = 300;
  localparam int DRAIN_WAIT = 600;
  localparam logic signed [31:0] ONE = 32'sd65536;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  out_item_t  pending_views[$];
  view_row_t  directed[$];
  int         n_sent;
  int         n_taken;
  int         n_errors;
  int         n_degenerate;
  int         cycles;

  look_at_view_matrix dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("tb_look_at_view_matrix failed");
      $finish;
    end
  end

  function automatic longint unsigned isqrt64(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic vec3_t scale_to_unit(vec3_t v);
    longint unsigned m [3];
    longint unsigned big = 0;
    longint unsigned total = 0;
    longint unsigned len;
    longint          q;
    vec3_t           u;
    int              k = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > big) big = m[i];
    end
    while ((big >> k) >= (64'd1 << 30)) k++;
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] >> k;
      total += m[i] * m[i];
    end
    len = isqrt64(total);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        u[i] = 0;
      end else begin
        q = ((m[i] << 17) + len) / (2 * len);
        u[i] = v[i] < 0 ? -q : q;
      end
    end
    return u;
  endfunction

  function automatic longint q32_to_q16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic logic [31:0] row_shift(vec3_t row, vec3_t eye);
    longint s;
    s = q32_to_q16(-(row[0] * eye[0] + row[1] * eye[1] + row[2] * eye[2]));
    if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
    if (s < -64'sh8000_0000) s = -64'sh8000_0000;
    return s[31:0];
  endfunction

  function automatic out_item_t build_view_rows(in_item_t a);
    vec3_t     eye, diff, fwd, raw, side, up, back;
    out_item_t r;
    eye[0] = longint'(a.eye_x);
    eye[1] = longint'(a.eye_y);
    eye[2] = longint'(a.eye_z);
    diff[0] = longint'(a.target_x) - eye[0];
    diff[1] = longint'(a.target_y) - eye[1];
    diff[2] = longint'(a.target_z) - eye[2];
    fwd = scale_to_unit(diff);
    raw[0] = fwd[1] * longint'(a.upvec_z) - fwd[2] * longint'(a.upvec_y);
    raw[1] = fwd[2] * longint'(a.upvec_x) - fwd[0] * longint'(a.upvec_z);
    raw[2] = fwd[0] * longint'(a.upvec_y) - fwd[1] * longint'(a.upvec_x);
    side = scale_to_unit(raw);
    up[0] = q32_to_q16(side[1] * fwd[2] - side[2] * fwd[1]);
    up[1] = q32_to_q16(side[2] * fwd[0] - side[0] * fwd[2]);
    up[2] = q32_to_q16(side[0] * fwd[1] - side[1] * fwd[0]);
    for (int i = 0; i < 3; i++) back[i] = -fwd[i];
    r.row0_x = 32'(side[0]);
    r.row0_y = 32'(side[1]);
    r.row0_z = 32'(side[2]);
    r.row0_shift = row_shift(side, eye);
    r.row1_x = 32'(up[0]);
    r.row1_y = 32'(up[1]);
    r.row1_z = 32'(up[2]);
    r.row1_shift = row_shift(up, eye);
    r.row2_x = 32'(back[0]);
    r.row2_y = 32'(back[1]);
    r.row2_z = 32'(back[2]);
    r.row2_shift = row_shift(back, eye);
    return r;
  endfunction

  function automatic logic [31:0] rand_small();
    return $urandom_range(0, 1) ? $urandom_range(0, 1 << 21) : -$urandom_range(0, 1 << 21);
  endfunction

  function automatic in_item_t random_camera();
    in_item_t a;
    int       mode;
    int       f;
    mode = $urandom_range(0, 9);
    a = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom};
    if (mode >= 3) begin
      a.eye_x = rand_small();
      a.eye_y = rand_small();
      a.eye_z = rand_small();
      a.target_x = rand_small();
      a.target_y = rand_small();
      a.target_z = rand_small();
      a.upvec_x = rand_small();
      a.upvec_y = rand_small();
      a.upvec_z = rand_small();
    end
    case (mode)
      3: begin
        a.target_x = a.eye_x;
        a.target_y = a.eye_y;
        a.target_z = a.eye_z;
      end
      4: begin
        f = $urandom_range(1, 3);
        a.upvec_x = (a.target_x - a.eye_x) * f;
        a.upvec_y = (a.target_y - a.eye_y) * f;
        a.upvec_z = (a.target_z - a.eye_z) * f;
      end
      5: a.upvec_x = 0;
      6: {a.upvec_x, a.upvec_y, a.upvec_z} = '0;
      default: ;
    endcase
    return a;
  endfunction

  function automatic view_row_t row_of(in_item_t a);
    view_row_t r;
    r.stim = a;
    r.known = 0;
    r.want = '0;
    return r;
  endfunction

  task automatic offer(in_item_t a, bit known, out_item_t want);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= a;
    do @(posedge clk); while (in_stall);
    pending_views.push_back(known ? want : build_view_rows(a));
    if (a.target_x == a.eye_x && a.target_y == a.eye_y && a.target_z == a.eye_z)
      n_degenerate++;
    n_sent++;
  endtask

  // result side
  initial begin
    int        hold;
    out_item_t want;
    logic [11:0][31:0] got_w, want_w;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = (n_taken == HOLD_AT) ? HOLD_LEN : $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0 && n_taken != HOLD_AT) hold = 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      n_taken++;
      if (pending_views.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item);
        n_errors++;
      end else begin
        want = pending_views.pop_front();
        got_w  = out_item;
        want_w = want;
        for (int i = 11; i >= 0; i--)
          if (got_w[i] !== want_w[i]) begin
            $display("%0t: field %0d expected %h actual %h", $time, 11 - i,
                     want_w[i], got_w[i]);
            n_errors++;
          end
      end
    end
  end

  initial begin
    in_item_t  a;
    view_row_t r;
    clk = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    cycles = 0;
    n_sent = 0;
    n_taken = 0;
    n_errors = 0;
    n_degenerate = 0;

    // all zero: every row zero
    r = row_of('0);
    r.known = 1;
    directed.push_back(r);
    // looking down -z with +y up from the origin: identity rows
    a = '0;
    a.target_z = -ONE;
    a.upvec_y = ONE;
    r = row_of(a);
    r.known = 1;
    r.want.row0_x = ONE;
    r.want.row1_y = ONE;
    r.want.row2_z = ONE;
    directed.push_back(r);
    // eye on target at the extremes: nothing to scale, rows zero
    a = {9{32'h7FFF_FFFF}};
    r = row_of(a);
    r.known = 1;
    directed.push_back(r);
    a = {9{32'h8000_0000}};
    r = row_of(a);
    r.known = 1;
    directed.push_back(r);
    a = {{3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}};
    directed.push_back(row_of(a));
    a = {{3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}};
    directed.push_back(row_of(a));
    a = '0;
    a.target_x = 32'h4000_0000;
    a.upvec_y = ONE;
    directed.push_back(row_of(a));
    a.target_x = 32'h3FFF_FFFF;
    a.upvec_z = 32'h8000_0000;
    directed.push_back(row_of(a));
    // up parallel to forward
    a = '0;
    a.target_x = ONE;
    a.target_y = 2 * ONE;
    a.upvec_x = 3 * ONE;
    a.upvec_y = 6 * ONE;
    directed.push_back(row_of(a));
    // up zero
    a = '0;
    a.target_z = 5 * ONE;
    directed.push_back(row_of(a));
    // far eye, translations saturate
    a = {{3{32'h7FFF_FFFF}}, {3{32'h0}}, 32'h0, ONE[31:0], 32'h0};
    directed.push_back(row_of(a));
    a = {{3{32'h8000_0001}}, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
         32'h7FFF_FFFF};
    directed.push_back(row_of(a));
    a = {32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h1,
         32'hFFFF_FFFF, 32'h0};
    directed.push_back(row_of(a));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) offer(directed[i].stim, directed[i].known, directed[i].want);
    repeat (N_RANDOM) offer(random_camera(), 0, '0);
    in_valid <= 1'b0;

    while (pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("%0d items sent, %0d results checked, %0d with eye on target",
             n_sent, n_taken, n_degenerate);
    $display("directed extremes, degenerate vectors and saturation, then random cameras");
    if (n_errors == 0) begin
      $display("tb_look_at_view_matrix passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("tb_look_at_view_matrix failed");
    end
    $finish;
  end

endmodule

// ===== look_at_view_matrix.f =====
+incdir+src
src/lavm_pkg.sv
src/lavm_front.sv
src/lavm_queue.sv
src/lavm_back.sv
src/look_at_view_matrix.sv
bench/tb_look_at_view_matrix.sv
